### sv/ipub_pkg.sv
`default_nettype none

package ipub_pkg;

	// Default limit on the size of one built packet, header included.
	localparam int unsigned MAX_PACKET_BYTES = 2048;

	// Header geometry.
	localparam int unsigned HDR_BYTES = 28;
	localparam int unsigned UDP_HDR_BYTES = 8;

	// Fixed header field values.
	localparam logic [7:0] IP_VER_IHL = 8'h45;
	localparam logic [15:0] IP_FLAGS_DF = 16'h4000;
	localparam logic [7:0] IP_TTL = 8'd64;
	localparam logic [7:0] IP_PROTO_UDP = 8'd17;
	localparam logic [15:0] CSUM_ZERO_SUBST = 16'hFFFF;

	// Sum of the constant words of the IPv4 header: version/IHL, flags and TTL/protocol.
	// It stays below 2^16, so no carry has to be folded back in.
	localparam logic [15:0] IP_FIXED_SUM = {IP_VER_IHL, 8'h00} + IP_FLAGS_DF
		+ {IP_TTL, IP_PROTO_UDP};

	// Widths of the values that travel from the front part to the back part.
	localparam int unsigned CNT_W = 16;
	localparam int unsigned OFF_W = 11;
	localparam int unsigned STEP_W = 5;

	// Depth of the queue between the front part and the back part.
	localparam int unsigned QUEUE_DEPTH = 4;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ADDRESS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DESTINATION_ADDRESS = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_PORT = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_PORT = 8'd3;

	typedef struct packed {
		logic [31:0] source_address;
		logic [31:0] destination_address;
		logic [15:0] src_port;
		logic [15:0] dst_port;
	} cfg_t;

	// One unit of work for the back part: an optional payload byte, then an
	// optional end of packet (header or error).
	typedef struct packed {
		logic             has_byte;
		logic [7:0]       data;
		logic [OFF_W-1:0] offset;
		logic             has_end;
		logic             err;
		logic [15:0]      ident;
		logic [CNT_W-1:0] count;
		logic [15:0]      sum;
	} entry_t;

	// Ones'-complement addition with end-around carry.
	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'b0, s[16]};
	endfunction

endpackage

`default_nettype wire

### sv/ipub_front.sv
`default_nettype none

module ipub_front #(
	parameter int unsigned MAX_PACKET_BYTES = ipub_pkg::MAX_PACKET_BYTES
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic [7:0]      data_byte,
	input  wire logic            byte_valid,
	input  wire logic            last,
	input  wire logic [15:0]     identification,
	output ipub_pkg::entry_t     entry,
	output logic                 entry_push
);

	localparam int unsigned LIMIT = MAX_PACKET_BYTES - ipub_pkg::HDR_BYTES;
	localparam int unsigned CW = (LIMIT > 1) ? $clog2(LIMIT + 1) : 1;
	localparam int unsigned CNT_W = ipub_pkg::CNT_W;

	logic [CW-1:0]    count_q;
	logic [15:0]      sum_q;
	logic [15:0]      ident_q;
	logic             ovf_q;
	logic             in_packet_q;

	logic             active;
	logic             room;
	logic             take;
	logic             ovf_set;
	logic [15:0]      ident_eff;
	logic [15:0]      byte_word;
	logic [15:0]      sum_next;
	logic [CW-1:0]    count_after;
	logic [CNT_W-1:0] offset_full;

	always_comb begin
		active = byte_valid | last;
		room = count_q < CW'(LIMIT);
		take = byte_valid & ~ovf_q & room;
		ovf_set = byte_valid & ~ovf_q & ~room;
		ident_eff = in_packet_q ? ident_q : identification;
		// Even payload positions are the high byte of a big-endian word.
		byte_word = count_q[0] ? {8'h00, data_byte} : {data_byte, 8'h00};
		sum_next = take ? ipub_pkg::ones_add(sum_q, byte_word) : sum_q;
		count_after = take ? count_q + 1'b1 : count_q;
		offset_full = CNT_W'(count_q) + CNT_W'(ipub_pkg::HDR_BYTES);

		entry.has_byte = take;
		entry.data = data_byte;
		entry.offset = offset_full[ipub_pkg::OFF_W-1:0];
		entry.has_end = last;
		entry.err = ovf_q | ovf_set;
		entry.ident = ident_eff;
		entry.count = CNT_W'(count_after);
		entry.sum = sum_next;

		entry_push = accept & (take | last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q <= '0;
			ident_q <= '0;
			ovf_q <= 1'b0;
			in_packet_q <= 1'b0;
		end else if (accept && active) begin
			if (last) begin
				count_q <= '0;
				sum_q <= '0;
				ident_q <= '0;
				ovf_q <= 1'b0;
				in_packet_q <= 1'b0;
			end else begin
				count_q <= count_after;
				sum_q <= sum_next;
				ident_q <= ident_eff;
				ovf_q <= ovf_q | ovf_set;
				in_packet_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### sv/ipub_queue.sv
`default_nettype none

module ipub_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	input  wire ipub_pkg::entry_t wr_entry,
	input  wire logic             rd,
	output ipub_pkg::entry_t      rd_entry,
	output logic                  full,
	output logic                  nonempty
);

	localparam int unsigned DEPTH = ipub_pkg::QUEUE_DEPTH;
	localparam int unsigned AW = $clog2(DEPTH);

	ipub_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;

	assign rd_entry = mem_q[rd_ptr_q];
	assign full = count_q == (AW+1)'(DEPTH);
	assign nonempty = count_q != '0;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### sv/ipub_back.sv
`default_nettype none

module ipub_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ipub_pkg::cfg_t               cfg,
	input  wire ipub_pkg::entry_t             entry,
	input  wire logic                         avail,
	output logic                              take,
	output logic                              empty,
	input  wire logic                         pop,
	output logic [ipub_pkg::OFF_W-1:0]        byte_offset,
	output logic [7:0]                        byte_value,
	output logic                              packet_done,
	output logic                              too_long
);

	localparam int unsigned STEP_W = ipub_pkg::STEP_W;
	localparam int unsigned OFF_W = ipub_pkg::OFF_W;
	localparam int unsigned CNT_W = ipub_pkg::CNT_W;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ipub_pkg::HDR_BYTES - 1);

	logic              busy_q;
	logic              byte_pend_q;
	logic              end_pend_q;
	logic              err_q;
	logic [7:0]        data_q;
	logic [OFF_W-1:0]  offset_q;
	logic [15:0]       ident_q;
	logic [15:0]       total_q;
	logic [15:0]       ulen_q;
	logic [STEP_W-1:0] step_q;
	logic [15:0]       ip_acc_q;
	logic [15:0]       udp_acc_q;

	logic              out_valid_q;
	logic [OFF_W-1:0]  out_offset_q;
	logic [7:0]        out_value_q;
	logic              out_done_q;
	logic              out_err_q;

	logic              slot;
	logic              emit;
	logic              last_step;
	logic              fin;
	logic [15:0]       ip_term;
	logic [15:0]       udp_term;
	logic [15:0]       ipck;
	logic [15:0]       udck_raw;
	logic [15:0]       udck;
	logic [7:0]        hdr_byte;
	logic [CNT_W-1:0]  total_full;
	logic [CNT_W-1:0]  ulen_full;

	always_comb begin
		slot = ~out_valid_q | pop;
		emit = busy_q & slot;
		last_step = step_q == LAST_STEP;
		fin = emit & (byte_pend_q ? ~end_pend_q : (err_q | last_step));
		take = avail & (~busy_q | fin);

		total_full = entry.count + CNT_W'(ipub_pkg::HDR_BYTES);
		ulen_full = entry.count + CNT_W'(ipub_pkg::UDP_HDR_BYTES);

		case (step_q)
			5'd0:    ip_term = total_q;
			5'd1:    ip_term = ident_q;
			5'd2:    ip_term = cfg.source_address[31:16];
			5'd3:    ip_term = cfg.source_address[15:0];
			5'd4:    ip_term = cfg.destination_address[31:16];
			5'd5:    ip_term = cfg.destination_address[15:0];
			default: ip_term = 16'h0000;
		endcase

		case (step_q)
			5'd0:    udp_term = cfg.source_address[31:16];
			5'd1:    udp_term = cfg.source_address[15:0];
			5'd2:    udp_term = cfg.destination_address[31:16];
			5'd3:    udp_term = cfg.destination_address[15:0];
			5'd4:    udp_term = {8'h00, ipub_pkg::IP_PROTO_UDP};
			5'd5:    udp_term = ulen_q;
			5'd6:    udp_term = ulen_q;
			5'd7:    udp_term = cfg.src_port;
			5'd8:    udp_term = cfg.dst_port;
			default: udp_term = 16'h0000;
		endcase

		ipck = ~ip_acc_q;
		udck_raw = ~udp_acc_q;
		udck = (udck_raw == 16'h0000) ? ipub_pkg::CSUM_ZERO_SUBST : udck_raw;

		case (step_q)
			5'd0:    hdr_byte = ipub_pkg::IP_VER_IHL;
			5'd1:    hdr_byte = 8'h00;
			5'd2:    hdr_byte = total_q[15:8];
			5'd3:    hdr_byte = total_q[7:0];
			5'd4:    hdr_byte = ident_q[15:8];
			5'd5:    hdr_byte = ident_q[7:0];
			5'd6:    hdr_byte = ipub_pkg::IP_FLAGS_DF[15:8];
			5'd7:    hdr_byte = ipub_pkg::IP_FLAGS_DF[7:0];
			5'd8:    hdr_byte = ipub_pkg::IP_TTL;
			5'd9:    hdr_byte = ipub_pkg::IP_PROTO_UDP;
			5'd10:   hdr_byte = ipck[15:8];
			5'd11:   hdr_byte = ipck[7:0];
			5'd12:   hdr_byte = cfg.source_address[31:24];
			5'd13:   hdr_byte = cfg.source_address[23:16];
			5'd14:   hdr_byte = cfg.source_address[15:8];
			5'd15:   hdr_byte = cfg.source_address[7:0];
			5'd16:   hdr_byte = cfg.destination_address[31:24];
			5'd17:   hdr_byte = cfg.destination_address[23:16];
			5'd18:   hdr_byte = cfg.destination_address[15:8];
			5'd19:   hdr_byte = cfg.destination_address[7:0];
			5'd20:   hdr_byte = cfg.src_port[15:8];
			5'd21:   hdr_byte = cfg.src_port[7:0];
			5'd22:   hdr_byte = cfg.dst_port[15:8];
			5'd23:   hdr_byte = cfg.dst_port[7:0];
			5'd24:   hdr_byte = ulen_q[15:8];
			5'd25:   hdr_byte = ulen_q[7:0];
			5'd26:   hdr_byte = udck[15:8];
			5'd27:   hdr_byte = udck[7:0];
			default: hdr_byte = 8'h00;
		endcase
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			byte_pend_q <= 1'b0;
			end_pend_q <= 1'b0;
			step_q <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			byte_pend_q <= entry.has_byte;
			end_pend_q <= entry.has_end;
			step_q <= '0;
		end else if (emit) begin
			if (byte_pend_q) begin
				byte_pend_q <= 1'b0;
				if (!end_pend_q) begin
					busy_q <= 1'b0;
				end
			end else if (err_q || last_step) begin
				busy_q <= 1'b0;
				end_pend_q <= 1'b0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// Work registers of the entry in progress; the checksums fold in one word
	// per header byte sent.
	always_ff @(posedge clk) begin
		if (take) begin
			err_q <= entry.err;
			data_q <= entry.data;
			offset_q <= entry.offset;
			ident_q <= entry.ident;
			total_q <= total_full[15:0];
			ulen_q <= ulen_full[15:0];
			ip_acc_q <= ipub_pkg::IP_FIXED_SUM;
			udp_acc_q <= entry.sum;
		end else if (emit && !byte_pend_q) begin
			ip_acc_q <= ipub_pkg::ones_add(ip_acc_q, ip_term);
			udp_acc_q <= ipub_pkg::ones_add(udp_acc_q, udp_term);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (byte_pend_q) begin
				out_offset_q <= offset_q;
				out_value_q <= data_q;
				out_done_q <= 1'b0;
				out_err_q <= 1'b0;
			end else if (err_q) begin
				out_offset_q <= '0;
				out_value_q <= 8'h00;
				out_done_q <= 1'b1;
				out_err_q <= 1'b1;
			end else begin
				out_offset_q <= OFF_W'(step_q);
				out_value_q <= hdr_byte;
				out_done_q <= last_step;
				out_err_q <= 1'b0;
			end
		end
	end

	assign empty = ~out_valid_q;
	assign byte_offset = out_offset_q;
	assign byte_value = out_value_q;
	assign packet_done = out_done_q;
	assign too_long = out_err_q;

endmodule

`default_nettype wire

### sv/ipv4_udp_packet_builder.sv
// IPv4/UDP packet builder.
// Input channel (push/full): one transaction per payload byte, with byte_valid, last and the
// packet's identification (taken from the first transaction of a packet). A transaction with
// byte_valid and last both low is accepted and ignored; byte_valid low with last high ends a
// packet without adding a byte of its own.
// Result channel (empty/pop): the oldest result waits on byte_offset, byte_value, packet_done
// and too_long while empty is low. Each payload byte comes out with offset 28 plus its payload
// position. After the last payload byte the 28 header bytes follow in offset order 0..27, the
// final one carrying packet_done. A packet that outgrows MAX_PACKET_BYTES loses its surplus
// bytes and ends with a single result carrying packet_done and too_long; it must be discarded.
// Configuration: cfg_valid/cfg_ready (always ready) writes the addresses and ports by index;
// write them only while no packet is in flight.
// A payload byte passes through the queue, the sequencer's work registers and the output register.
// Throughput: one payload byte per cycle while full and pop allow it. Each header leaves the
// output stage one byte per cycle while pop keeps up, with the checksums folded in one word per
// cycle alongside; a four-entry queue between the input side and the output sequencer lets input
// continue meanwhile, and full rises once it fills.
// When pop stays low the output register holds, the sequencer waits and the queue fills,
// after which full holds off the sender. Reset empties the queue and the output, clears the
// packet state and sets all configuration registers to zero.
`default_nettype none

module ipv4_udp_packet_builder #(
	parameter int unsigned MAX_PACKET_BYTES = ipub_pkg::MAX_PACKET_BYTES
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,

	input  wire logic                              push,
	output logic                                   full,
	input  wire logic [7:0]                        data_byte,
	input  wire logic                              byte_valid,
	input  wire logic                              last,
	input  wire logic [15:0]                       identification,

	output logic                                   empty,
	input  wire logic                              pop,
	output logic [ipub_pkg::OFF_W-1:0]             byte_offset,
	output logic [7:0]                             byte_value,
	output logic                                   packet_done,
	output logic                                   too_long,

	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [ipub_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [31:0]                       cfg_data
);

	ipub_pkg::cfg_t   cfg_q;
	ipub_pkg::entry_t front_entry;
	ipub_pkg::entry_t queue_entry;
	logic             accept;
	logic             entry_push;
	logic             queue_nonempty;
	logic             queue_take;

	// The register file takes a write on every cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				ipub_pkg::CFG_SOURCE_ADDRESS: begin
					cfg_q.source_address <= cfg_data;
				end
				ipub_pkg::CFG_DESTINATION_ADDRESS: begin
					cfg_q.destination_address <= cfg_data;
				end
				ipub_pkg::CFG_SRC_PORT: begin
					cfg_q.src_port <= cfg_data[15:0];
				end
				ipub_pkg::CFG_DST_PORT: begin
					cfg_q.dst_port <= cfg_data[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	// An input transaction completes whenever the queue has room; transactions
	// that produce no work are simply dropped by the front part.
	assign accept = push & ~full;

	ipub_front #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (data_byte),
		.byte_valid    (byte_valid),
		.last          (last),
		.identification(identification),
		.entry         (front_entry),
		.entry_push    (entry_push)
	);

	ipub_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (entry_push),
		.wr_entry(front_entry),
		.rd      (queue_take),
		.rd_entry(queue_entry),
		.full    (full),
		.nonempty(queue_nonempty)
	);

	ipub_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.entry      (queue_entry),
		.avail      (queue_nonempty),
		.take       (queue_take),
		.empty      (empty),
		.pop        (pop),
		.byte_offset(byte_offset),
		.byte_value (byte_value),
		.packet_done(packet_done),
		.too_long   (too_long)
	);

endmodule

`default_nettype wire

### tb/sv/ipub_tb_pkg.sv
`timescale 1ns / 100ps

package ipub_tb_pkg;

	import ipub_pkg::*;

	// One transaction on the input side.
	typedef struct packed {
		logic [7:0]  data;
		logic        valid;
		logic        last;
		logic [15:0] ident;
	} payload_item_t;

	// One transaction on the result side.
	typedef struct packed {
		logic [OFF_W-1:0] offset;
		logic [7:0]       value;
		logic             done;
		logic             err;
	} packet_byte_t;

	class udp_packet_checker;

		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;

		logic [31:0] running_sum;
		int unsigned payload_len;
		logic [15:0] ident_latch;
		bit          overflow_seen;
		bit          open_packet;

		packet_byte_t expected_bytes[$];
		int unsigned  error_count;
		int unsigned  checked_count;

		function new();
			src_addr = '0;
			dst_addr = '0;
			src_port = '0;
			dst_port = '0;
			error_count = 0;
			checked_count = 0;
			clear_packet();
		endfunction

		function void clear_packet();
			running_sum = '0;
			payload_len = 0;
			ident_latch = '0;
			overflow_seen = 0;
			open_packet = 0;
		endfunction

		function void set_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
			case (idx)
				CFG_SOURCE_ADDRESS:      src_addr = val;
				CFG_DESTINATION_ADDRESS: dst_addr = val;
				CFG_SRC_PORT:            src_port = val[15:0];
				CFG_DST_PORT:            dst_port = val[15:0];
				default: ;
			endcase
		endfunction

		// Ones'-complement fold of a wide sum, inverted.
		static function logic [15:0] complement_fold(input logic [31:0] s);
			while (s[31:16] != 16'h0)
				s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
			return ~s[15:0];
		endfunction

		function void expect_byte(input int unsigned off, input logic [7:0] val,
				input logic done, input logic err);
			packet_byte_t b;
			b.offset = off[OFF_W-1:0];
			b.value = val;
			b.done = done;
			b.err = err;
			expected_bytes.push_back(b);
		endfunction

		function void build_header();
			logic [7:0]  hdr [HDR_BYTES];
			logic [15:0] total_len;
			logic [15:0] udp_len;
			logic [15:0] ip_sum;
			logic [15:0] udp_sum;
			logic [31:0] s;
			total_len = 16'(HDR_BYTES + payload_len);
			udp_len = 16'(UDP_HDR_BYTES + payload_len);

			s = 32'({IP_VER_IHL, 8'h00}) + 32'(total_len) + 32'(ident_latch) + 32'(IP_FLAGS_DF)
				+ 32'({IP_TTL, IP_PROTO_UDP}) + 32'(src_addr[31:16]) + 32'(src_addr[15:0])
				+ 32'(dst_addr[31:16]) + 32'(dst_addr[15:0]);
			ip_sum = complement_fold(s);

			// Pseudo-header, UDP header and payload; the UDP length counts twice.
			s = 32'(src_addr[31:16]) + 32'(src_addr[15:0]) + 32'(dst_addr[31:16])
				+ 32'(dst_addr[15:0]) + 32'(IP_PROTO_UDP) + 32'(udp_len) + 32'(src_port)
				+ 32'(dst_port) + 32'(udp_len) + running_sum;
			udp_sum = complement_fold(s);
			if (udp_sum == 16'h0)
				udp_sum = CSUM_ZERO_SUBST;

			hdr[0] = IP_VER_IHL;            hdr[1] = 8'h00;
			hdr[2] = total_len[15:8];       hdr[3] = total_len[7:0];
			hdr[4] = ident_latch[15:8];     hdr[5] = ident_latch[7:0];
			hdr[6] = IP_FLAGS_DF[15:8];     hdr[7] = IP_FLAGS_DF[7:0];
			hdr[8] = IP_TTL;                hdr[9] = IP_PROTO_UDP;
			hdr[10] = ip_sum[15:8];         hdr[11] = ip_sum[7:0];
			hdr[12] = src_addr[31:24];      hdr[13] = src_addr[23:16];
			hdr[14] = src_addr[15:8];       hdr[15] = src_addr[7:0];
			hdr[16] = dst_addr[31:24];      hdr[17] = dst_addr[23:16];
			hdr[18] = dst_addr[15:8];       hdr[19] = dst_addr[7:0];
			hdr[20] = src_port[15:8];       hdr[21] = src_port[7:0];
			hdr[22] = dst_port[15:8];       hdr[23] = dst_port[7:0];
			hdr[24] = udp_len[15:8];        hdr[25] = udp_len[7:0];
			hdr[26] = udp_sum[15:8];        hdr[27] = udp_sum[7:0];

			for (int i = 0; i < HDR_BYTES; i++)
				expect_byte(i, hdr[i], i == HDR_BYTES - 1, 1'b0);
		endfunction

		// Called for every accepted input transaction.
		function void take_payload_item(input payload_item_t item);
			if (!item.valid && !item.last)
				return;

			if (!open_packet) begin
				open_packet = 1;
				ident_latch = item.ident;
			end

			if (item.valid && !overflow_seen) begin
				if (HDR_BYTES + payload_len + 1 > MAX_PACKET_BYTES) begin
					overflow_seen = 1;
				end else begin
					if (payload_len[0] == 1'b0)
						running_sum += {16'h0, item.data, 8'h00};
					else
						running_sum += {24'h0, item.data};
					expect_byte(HDR_BYTES + payload_len, item.data, 1'b0, 1'b0);
					payload_len++;
				end
			end

			if (!item.last)
				return;

			if (overflow_seen)
				expect_byte(0, 8'h00, 1'b1, 1'b1);
			else
				build_header();
			clear_packet();
		endfunction

		function void flag_error(input string what);
			error_count++;
			if (error_count <= 10)
				$display("[%0t] ERROR: %s", $realtime, what);
		endfunction

		// Called for every accepted result transaction.
		function void check_packet_byte(input packet_byte_t got);
			packet_byte_t want;
			checked_count++;
			if (expected_bytes.size() == 0) begin
				flag_error($sformatf("unexpected result off=%0d val=%02h done=%0b err=%0b",
					got.offset, got.value, got.done, got.err));
				return;
			end
			want = expected_bytes.pop_front();
			if (got !== want)
				flag_error($sformatf({"result mismatch: expected off=%0d val=%02h done=%0b ",
					"err=%0b, got off=%0d val=%02h done=%0b err=%0b"},
					want.offset, want.value, want.done, want.err,
					got.offset, got.value, got.done, got.err));
		endfunction

		// Anything still expected at the end never arrived.
		function void close_out();
			if (expected_bytes.size() != 0) begin
				$display("ERROR: %0d expected results never arrived", expected_bytes.size());
				error_count += expected_bytes.size();
			end
		endfunction

	endclass

endpackage

### tb/sv/ipv4_udp_packet_builder_tb.sv
`timescale 1ns / 100ps

module ipv4_udp_packet_builder_tb;

	import ipub_pkg::*;
	import ipub_tb_pkg::*;

	// Random payload items to send after the directed part, split over four phases.
	localparam int unsigned RANDOM_ITEMS = 400;
	// Time for a payload byte to reach the result ports and a header to follow; this covers
	// any idle transaction that may still be in flight before a register write.
	localparam int unsigned SETTLE_CYCLES = 48;
	// Upper bound on waiting for outstanding results at a phase boundary.
	localparam int unsigned DRAIN_LIMIT = 20000;
	// About 6600 items are sent in all; even if each caused 29 results, taken at the
	// random pop rate and with the hold-off, the run would finish well within CYCLE_LIMIT.
	localparam int unsigned CYCLE_LIMIT = 2000000;
	// The long receiver hold-off starts once this many results have been taken.
	localparam int unsigned HOLD_AT = 1000;
	localparam int unsigned HOLD_CYCLES = 400;
	// Window of results in which the receiver never idles.
	localparam int unsigned STEADY_POP_LO = 2500;
	localparam int unsigned STEADY_POP_HI = 4500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        push = 1'b0;
	logic        full;
	logic [7:0]  data_byte = 8'h00;
	logic        byte_valid = 1'b0;
	logic        last = 1'b0;
	logic [15:0] identification = 16'h0000;

	logic             empty;
	logic             pop = 1'b0;
	logic [OFF_W-1:0] byte_offset;
	logic [7:0]       byte_value;
	logic             packet_done;
	logic             too_long;

	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = 32'h0;

	udp_packet_checker sb = new();

	// Items waiting to be offered on the input side, in order.
	payload_item_t stim_q[$];
	// When set, the sender offers an item every cycle it has one.
	bit sender_steady = 1'b0;

	ipv4_udp_packet_builder DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.data_byte      (data_byte),
		.byte_valid     (byte_valid),
		.last           (last),
		.identification (identification),
		.empty          (empty),
		.pop            (pop),
		.byte_offset    (byte_offset),
		.byte_value     (byte_value),
		.packet_done    (packet_done),
		.too_long       (too_long),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Input side. Every cycle it either offers the item at the head of stim_q or
	// idles. An item that is being held off by full stays on the port until it is
	// taken, so idling only ever starts between transactions. All outputs of the
	// block are sampled right after the clock edge, before its registers move.
	initial begin : input_driver
		payload_item_t head;
		bit held;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (stim_q.size() != 0 && (held || sender_steady || $urandom_range(99) >= 22)) begin
				head = stim_q[0];
				push <= 1'b1;
				data_byte <= head.data;
				byte_valid <= head.valid;
				last <= head.last;
				identification <= head.ident;
			end else begin
				push <= 1'b0;
			end
			@(posedge clk);
			held = 1'b0;
			if (push) begin
				if (!full) begin
					head.data = data_byte;
					head.valid = byte_valid;
					head.last = last;
					head.ident = identification;
					sb.take_payload_item(head);
					void'(stim_q.pop_front());
				end else begin
					held = 1'b1;
				end
			end
		end
	end

	// Result side. It idles at random except inside a window where it pops every
	// cycle, and once it stops popping for a long stretch so that the internal
	// queue fills and full pushes back on the sender.
	initial begin : result_sink
		packet_byte_t got;
		int unsigned stall_left;
		bit hold_done;
		stall_left = 0;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!hold_done && sb.checked_count >= HOLD_AT) begin
				hold_done = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left != 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (sb.checked_count >= STEADY_POP_LO && sb.checked_count < STEADY_POP_HI) begin
				pop <= 1'b1;
			end else begin
				pop <= ($urandom_range(99) >= 22);
			end
			@(posedge clk);
			if (pop && !empty) begin
				got.offset = byte_offset;
				got.value = byte_value;
				got.done = packet_done;
				got.err = too_long;
				sb.check_packet_byte(got);
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("ERROR: run did not finish within %0d cycles", CYCLE_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic enqueue(input logic [7:0] data, input logic valid, input logic lst,
			input logic [15:0] ident);
		payload_item_t item;
		item.data = data;
		item.valid = valid;
		item.last = lst;
		item.ident = ident;
		stim_q.push_back(item);
	endtask

	// Queues one packet of len random payload bytes. With empty_end, or when len is 0, the
	// packet is closed by a separate transaction that carries last but no byte. Idle
	// transactions are mixed in at noise_pct percent. Returns the transactions queued that
	// carry a byte or last, idle ones excluded.
	task automatic enqueue_packet(input int unsigned len, input bit empty_end,
			input int unsigned noise_pct, output int unsigned queued);
		queued = 0;
		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(99) < noise_pct)
				enqueue(8'($urandom), 1'b0, 1'b0, 16'($urandom));
			enqueue(8'($urandom), 1'b1, !empty_end && i == len - 1, 16'($urandom));
			queued++;
		end
		if (empty_end || len == 0) begin
			enqueue(8'($urandom), 1'b0, 1'b1, 16'($urandom));
			queued++;
		end
	endtask

	// Lets every queued item go in and every expected result come out, then waits
	// out the pipeline in case an idle transaction is still moving through it.
	task automatic settle();
		int unsigned waited;
		waited = 0;
		while (stim_q.size() != 0)
			@(posedge clk);
		while (sb.expected_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// cfg_valid is left high between back-to-back writes and lowered by the caller.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_register(idx, val);
	endtask

	task automatic write_config(input logic [31:0] src_addr, input logic [31:0] dst_addr,
			input logic [15:0] src_port, input logic [15:0] dst_port);
		write_reg(CFG_SOURCE_ADDRESS, src_addr);
		write_reg(CFG_DESTINATION_ADDRESS, dst_addr);
		write_reg(CFG_SRC_PORT, {16'h0, src_port});
		write_reg(CFG_DST_PORT, {16'h0, dst_port});
		cfg_valid <= 1'b0;
	endtask

	initial begin : test_sequence
		int unsigned phase_items;
		int unsigned queued;
		int unsigned len;
		int unsigned pick;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// All-zero registers first: this makes the zero UDP checksum case easy to hit.
		write_config(32'h0, 32'h0, 16'h0, 16'h0);

		// Empty payload: last without a byte yields only the header.
		enqueue(8'hFF, 1'b0, 1'b1, 16'hFFFF);
		// A lone idle transaction produces nothing.
		enqueue(8'hFF, 1'b0, 1'b0, 16'h1234);
		// One byte that is also last; the odd byte is padded with a zero low byte.
		enqueue(8'hFF, 1'b1, 1'b1, 16'h0000);
		// With zero registers and UDP length 10, the payload word 0xFFDA makes the
		// sum 0xFFFF, so the computed checksum is zero and must go out as 0xFFFF.
		enqueue(8'hFF, 1'b1, 1'b0, 16'h8001);
		enqueue(8'hDA, 1'b1, 1'b1, 16'h7FFE);
		// Odd payload with an idle transaction inside, closed by an empty last.
		enqueue(8'h00, 1'b1, 1'b0, 16'hA5A5);
		enqueue(8'h80, 1'b1, 1'b0, 16'h0000);
		enqueue(8'h33, 1'b0, 1'b0, 16'hFFFF);
		enqueue(8'h01, 1'b1, 1'b0, 16'h0000);
		enqueue(8'h00, 1'b0, 1'b1, 16'h5A5A);
		settle();

		// All-ones registers.
		write_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		// An idle transaction ahead of a packet must not latch its identification.
		enqueue(8'h00, 1'b0, 1'b0, 16'h0F0F);
		enqueue(8'hFF, 1'b1, 1'b0, 16'hF0F0);
		enqueue(8'h00, 1'b1, 1'b0, 16'h0000);
		enqueue(8'h7F, 1'b1, 1'b1, 16'hFFFF);
		// Largest packet that fits: the last payload byte lands at offset 2047.
		enqueue_packet(MAX_PACKET_BYTES - HDR_BYTES, 1'b0, 0, queued);
		// One byte too many: the surplus byte is dropped and last carries a byte.
		enqueue_packet(MAX_PACKET_BYTES - HDR_BYTES + 1, 1'b0, 0, queued);
		// Well over the limit with idle noise, closed by an empty last.
		enqueue_packet(MAX_PACKET_BYTES - HDR_BYTES + 10, 1'b1, 3, queued);
		settle();

		// Random traffic under four register settings. Packets are mostly short,
		// with some empty ones and a few of moderate length.
		for (int phase = 0; phase < 4; phase++) begin
			if (phase == 0)
				write_config(32'hAAAA_AAAA, 32'h5555_5555, 16'h5555, 16'hAAAA);
			else
				write_config($urandom, $urandom, 16'($urandom), 16'($urandom));
			sender_steady = (phase == 2);
			phase_items = 0;
			while (phase_items < RANDOM_ITEMS / 4) begin
				pick = $urandom_range(99);
				if (pick < 10)
					len = 0;
				else if (pick < 88)
					len = $urandom_range(24, 1);
				else
					len = $urandom_range(120, 25);
				enqueue_packet(len, $urandom_range(99) < 20, 6, queued);
				phase_items += queued;
			end
			settle();
		end
		sender_steady = 1'b0;

		sb.close_out();
		if (sb.error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
